@@ src/tld_pkg.sv @@
// Shared constants, types and helpers for the tagged-length deframer.
package tld_pkg;

	localparam int LENGTH_DIGITS_DEF = 13;
	localparam int LENGTH_WIDTH_DEF  = 32;
	localparam int BYTE_W            = 8;
	localparam int TAG_LEN           = 6;
	localparam int TAG_IDX_W         = 3;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic  valid;
		byte_t payload_byte;
		logic  frame_first;
		logic  frame_last;
		logic  frame_empty;
	} tld_result_t;

	function automatic byte_t tag_byte(input logic [TAG_IDX_W-1:0] idx);
		byte_t b;
		unique case (idx)
			3'd0: b = 8'h49; // I
			3'd1: b = 8'h41; // A
			3'd2: b = 8'h4C; // L
			3'd3: b = 8'h41; // A
			3'd4: b = 8'h52; // R
			3'd5: b = 8'h4D; // M
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ src/tld_ifs.sv @@
// Stream interfaces for received bytes and deframed results.
interface tld_in_if import tld_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tld_out_if import tld_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t payload_byte;
	logic  frame_first;
	logic  frame_last;
	logic  frame_empty;

	modport source (output valid, output payload_byte, output frame_first,
		output frame_last, output frame_empty, input ready);
	modport sink   (input valid, input payload_byte, input frame_first,
		input frame_last, input frame_empty, output ready);
endinterface

@@ src/tld_parser.sv @@
// Header parser state machine: tag hunt, separator skip, length digits and payload count.
module tld_parser import tld_pkg::*; #(
	parameter int LENGTH_DIGITS = LENGTH_DIGITS_DEF,
	parameter int LENGTH_WIDTH  = LENGTH_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  byte_t       data,
	output tld_result_t res
);

	localparam int DIG_W = $clog2(LENGTH_DIGITS + 1);
	localparam int MAC_W = LENGTH_WIDTH + 4;
	localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(LENGTH_DIGITS - 1);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_SEP     = 2'd1;
	localparam logic [1:0] PH_DIGITS  = 2'd2;
	localparam logic [1:0] PH_PAYLOAD = 2'd3;

	logic [1:0]              phase_q, phase_n;
	logic [TAG_IDX_W-1:0]    tag_q, tag_n;
	logic [DIG_W-1:0]        digits_q, digits_n;
	logic [LENGTH_WIDTH-1:0] sum_q, sum_n;
	logic                    bad_q, bad_n;
	logic [LENGTH_WIDTH-1:0] left_q, left_n;
	logic                    first_q, first_n;

	logic                    is_digit;
	logic [MAC_W-1:0]        mac;
	logic [LENGTH_WIDTH-1:0] len;

	assign is_digit = (data >= 8'h30) && (data <= 8'h39);
	assign mac = {1'b0, sum_q, 3'b000} + {3'b000, sum_q, 1'b0} + MAC_W'(data[3:0]);

	always_comb begin
		phase_n  = phase_q;
		tag_n    = tag_q;
		digits_n = digits_q;
		sum_n    = sum_q;
		bad_n    = bad_q;
		left_n   = left_q;
		first_n  = first_q;
		len      = '0;
		res      = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (data == tag_byte(tag_q)) begin
					tag_n = tag_q + 3'd1;
				end else begin
					tag_n = (data == tag_byte(3'd0)) ? 3'd1 : 3'd0;
				end
				if (tag_n == TAG_IDX_W'(TAG_LEN)) begin
					tag_n   = '0;
					phase_n = PH_SEP;
				end
			end
			PH_SEP: begin
				phase_n  = PH_DIGITS;
				digits_n = '0;
				sum_n    = '0;
				bad_n    = 1'b0;
			end
			PH_DIGITS: begin
				if (!is_digit) begin
					bad_n = 1'b1;
				end else if (!bad_q) begin
					if (mac[MAC_W-1:LENGTH_WIDTH] != '0) begin
						bad_n = 1'b1;
					end else begin
						sum_n = mac[LENGTH_WIDTH-1:0];
					end
				end
				if (digits_q == DIG_LAST) begin
					len      = bad_n ? '0 : sum_n;
					digits_n = '0;
					bad_n    = 1'b0;
					sum_n    = len;
					if (len == '0) begin
						phase_n         = PH_HUNT;
						res.valid       = 1'b1;
						res.frame_last  = 1'b1;
						res.frame_empty = 1'b1;
					end else begin
						left_n  = len;
						first_n = 1'b1;
						phase_n = PH_PAYLOAD;
					end
				end else begin
					digits_n = digits_q + 1'b1;
				end
			end
			PH_PAYLOAD: begin
				res.valid        = 1'b1;
				res.payload_byte = data;
				res.frame_first  = first_q;
				res.frame_last   = (left_q <= LENGTH_WIDTH'(1));
				first_n          = 1'b0;
				if (left_q != '0) begin
					left_n = left_q - 1'b1;
				end
				if (res.frame_last) begin
					phase_n = PH_HUNT;
				end
			end
			default: phase_n = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			tag_q    <= '0;
			digits_q <= '0;
			sum_q    <= '0;
			bad_q    <= 1'b0;
			left_q   <= '0;
			first_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			tag_q    <= tag_n;
			digits_q <= digits_n;
			sum_q    <= sum_n;
			bad_q    <= bad_n;
			left_q   <= left_n;
			first_q  <= first_n;
		end
	end

endmodule

@@ src/tagged_length_deframer.sv @@
// Top level of the tagged-length deframer: input register, parser, result register.
// Takes one received byte per clock and sustains one byte per cycle with both
// sides free. A byte goes into an input register, is parsed from there, and
// its result (if any) is registered in the result register. Bytes are dropped
// until the tag "IALARM", one separator byte is skipped, LENGTH_DIGITS ASCII
// digits give the length, and that many payload bytes follow with first/last
// marks. A bad or zero length gives one result with frame_empty and
// frame_last set. While the result register holds an untaken result, only
// bytes that produce no result advance.
module tagged_length_deframer import tld_pkg::*; #(
	parameter int LENGTH_DIGITS = LENGTH_DIGITS_DEF,
	parameter int LENGTH_WIDTH  = LENGTH_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tld_in_if.sink    rx,
	tld_out_if.source tx
);

	logic        valid_s1;
	byte_t       byte_s1;
	tld_result_t res;
	logic        out_free;
	logic        proc;

	logic        out_valid_q;
	byte_t       out_byte_q;
	logic        out_first_q;
	logic        out_last_q;
	logic        out_empty_q;

	tld_parser #(
		.LENGTH_DIGITS(LENGTH_DIGITS),
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (proc),
		.data  (byte_s1),
		.res   (res)
	);

	assign out_free = !out_valid_q || tx.ready;
	assign proc     = valid_s1 && (!res.valid || out_free);
	assign rx.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res.valid) begin
			out_byte_q  <= res.payload_byte;
			out_first_q <= res.frame_first;
			out_last_q  <= res.frame_last;
			out_empty_q <= res.frame_empty;
		end
	end

	assign tx.valid        = out_valid_q;
	assign tx.payload_byte = out_byte_q;
	assign tx.frame_first  = out_first_q;
	assign tx.frame_last   = out_last_q;
	assign tx.frame_empty  = out_empty_q;

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.frame_empty |->
			tx.frame_last && !tx.frame_first && (tx.payload_byte == 8'h00))
		else $error("empty-frame result malformed");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !proc |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input register changed");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> rx.ready)
		else $error("input not ready with empty input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !tx.ready |-> !(proc && res.valid))
		else $error("result register overwritten while stalled");

endmodule

@@ verif/testbench.sv @@
// Testbench for the tagged-length deframer: byte stream driver, parser model, result checker.
`timescale 1ns / 100ps

module testbench;
	import tld_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 80;
	localparam int CALM_FROM    = 260;
	localparam int CALM_TO      = 420;
	localparam logic [8*TAG_LEN-1:0] ALARM_TAG = "IALARM";
	localparam logic [LENGTH_WIDTH_DEF-1:0] LEN_LIMIT = '1;

	typedef enum logic [1:0] {SEEK_TAG, SKIP_SEP, READ_LENGTH, PASS_PAYLOAD} deframe_phase_t;

	typedef struct packed {
		byte_t payload_byte;
		logic  frame_first;
		logic  frame_last;
		logic  frame_empty;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tld_in_if  rx_if ();
	tld_out_if tx_if ();

	tagged_length_deframer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	always #5 clk = ~clk;

	byte_t         pending_bytes[$];
	frame_result_t expected_results[$];

	int  in_count = 0;
	int  cycle_cnt = 0;
	int  mismatches = 0;
	int  hold_at = -1;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  rx_fired = 1'b0;
	int  frames_seen = 0;
	int  empty_seen = 0;
	int  payload_seen = 0;
	int  hold_stalls = 0;
	logic calm;

	assign calm = in_count >= CALM_FROM && in_count < CALM_TO;

	// parser state
	deframe_phase_t              phase = SEEK_TAG;
	logic [TAG_IDX_W-1:0]        tag_cnt = '0;
	logic [3:0]                  digit_cnt = '0;
	logic [LENGTH_WIDTH_DEF-1:0] len_acc = '0;
	logic                        len_bad = 1'b0;
	logic [LENGTH_WIDTH_DEF-1:0] bytes_rem = '0;

	function automatic byte_t tag_char(input int k);
		return ALARM_TAG[8*(TAG_LEN-1-k) +: 8];
	endfunction

	function automatic bit deframe_byte(input byte_t b, output frame_result_t r);
		logic [LENGTH_WIDTH_DEF-1:0] d;
		logic [LENGTH_WIDTH_DEF-1:0] frame_len;
		r = '0;
		case (phase)
			SEEK_TAG: begin
				if (tag_cnt < TAG_LEN && b == tag_char(tag_cnt))
					tag_cnt = tag_cnt + 1'b1;
				else
					tag_cnt = (b == tag_char(0)) ? 3'd1 : 3'd0;
				if (tag_cnt >= TAG_LEN) begin
					tag_cnt = '0;
					phase = SKIP_SEP;
				end
				return 1'b0;
			end
			SKIP_SEP: begin
				phase = READ_LENGTH;
				digit_cnt = '0;
				len_acc = '0;
				len_bad = 1'b0;
				return 1'b0;
			end
			READ_LENGTH: begin
				if (b >= "0" && b <= "9") begin
					d = LENGTH_WIDTH_DEF'(b - "0");
					if (!len_bad) begin
						if (len_acc > (LEN_LIMIT - d) / 10)
							len_bad = 1'b1;
						else
							len_acc = len_acc * 10 + d;
					end
				end else begin
					len_bad = 1'b1;
				end
				if (digit_cnt + 1 >= LENGTH_DIGITS_DEF) begin
					frame_len = len_bad ? '0 : len_acc;
					digit_cnt = '0;
					len_bad = 1'b0;
					len_acc = frame_len;
					if (frame_len == 0) begin
						phase = SEEK_TAG;
						r.frame_last = 1'b1;
						r.frame_empty = 1'b1;
						return 1'b1;
					end
					bytes_rem = frame_len;
					phase = PASS_PAYLOAD;
				end else begin
					digit_cnt = digit_cnt + 1'b1;
				end
				return 1'b0;
			end
			default: begin
				r.payload_byte = b;
				r.frame_first = bytes_rem == len_acc;
				r.frame_last = bytes_rem <= 1;
				if (bytes_rem > 0)
					bytes_rem = bytes_rem - 1'b1;
				if (r.frame_last)
					phase = SEEK_TAG;
				return 1'b1;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && (!rx_if.valid || rx_fired)) begin
			if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
				rx_if.valid <= 1'b1;
				rx_if.rx_byte <= pending_bytes.pop_front();
			end else begin
				rx_if.valid <= 1'b0;
				rx_if.rx_byte <= byte_t'($urandom);
			end
		end
	end

	// receiver, with one long hold-off while the sender keeps offering
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			tx_if.ready <= 1'b0;
		end else if (!hold_done && hold_at >= 0 && in_count >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			tx_if.ready <= 1'b0;
		end else begin
			tx_if.ready <= calm || $urandom_range(99) >= 35;
		end
	end

	always @(posedge clk) begin : result_monitor
		frame_result_t r;
		frame_result_t want;
		rx_fired <= arst_n && rx_if.valid && rx_if.ready;
		if (arst_n) begin
			if (hold_left != 0 && rx_if.valid && !rx_if.ready)
				hold_stalls++;
			if (rx_if.valid && rx_if.ready) begin
				in_count <= in_count + 1;
				if (deframe_byte(rx_if.rx_byte, r))
					expected_results.push_back(r);
			end
			if (tx_if.valid && tx_if.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result byte %02h",
						tx_if.payload_byte));
				end else begin
					want = expected_results.pop_front();
					if (tx_if.payload_byte !== want.payload_byte)
						report_mismatch($sformatf("payload_byte %02h, want %02h",
							tx_if.payload_byte, want.payload_byte));
					if (tx_if.frame_first !== want.frame_first)
						report_mismatch($sformatf("frame_first %b, want %b",
							tx_if.frame_first, want.frame_first));
					if (tx_if.frame_last !== want.frame_last)
						report_mismatch($sformatf("frame_last %b, want %b",
							tx_if.frame_last, want.frame_last));
					if (tx_if.frame_empty !== want.frame_empty)
						report_mismatch($sformatf("frame_empty %b, want %b",
							tx_if.frame_empty, want.frame_empty));
					if (want.frame_last)
						frames_seen++;
					if (want.frame_empty)
						empty_seen++;
					else
						payload_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic queue_tag(input int n);
		for (int k = 0; k < n; k++)
			pending_bytes.push_back(tag_char(k));
	endtask

	// tag, separator and length field; bad_pos >= 0 replaces that digit
	task automatic queue_header(input byte_t sep, input longint unsigned value,
		input int bad_pos, input byte_t bad_char);
		longint unsigned scale;
		scale = 1;
		repeat (LENGTH_DIGITS_DEF - 1) scale = scale * 10;
		queue_tag(TAG_LEN);
		pending_bytes.push_back(sep);
		for (int k = 0; k < LENGTH_DIGITS_DEF; k++) begin
			if (k == bad_pos)
				pending_bytes.push_back(bad_char);
			else
				pending_bytes.push_back(byte_t'("0" + (value / scale) % 10));
			scale = scale / 10;
		end
	endtask

	task automatic queue_payload(input int n);
		repeat (n) pending_bytes.push_back(byte_t'($urandom));
	endtask

	function automatic byte_t non_digit();
		byte_t b;
		do b = byte_t'($urandom_range(255)); while (b >= "0" && b <= "9");
		return b;
	endfunction

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || rx_if.valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int frame_bytes;
		int len;
		int pick;
		int n;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		tx_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// broken tag, then a doubled I before the real tag; zero length
		pending_bytes.push_back("I");
		pending_bytes.push_back("A");
		pending_bytes.push_back("L");
		pending_bytes.push_back("I");
		pending_bytes.push_back("I");
		queue_header(8'hFF, 0, -1, 8'h00);
		// one-byte frame, extreme payload value
		queue_header(8'h00, 1, -1, 8'h00);
		pending_bytes.push_back(8'h00);
		// tag inside the payload is just data
		queue_header(" ", 8, -1, 8'h00);
		queue_tag(TAG_LEN);
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(8'h7F);
		// bad characters next to the digit range, whitespace and a dash
		queue_header("I", 5, 12, ":");
		queue_header(8'h80, 5, 0, "/");
		queue_header(8'h55, 5, 6, " ");
		queue_header(8'hAA, 5, 3, "-");
		// just above the length range, and the largest field value
		queue_header(8'h01, 64'd4294967296, -1, 8'h00);
		queue_header(8'hFE, 64'd9999999999999, -1, 8'h00);
		pending_bytes.push_back("x");

		wait_drained();

		// long frame first so the hold-off lands inside its payload
		hold_at = in_count + 30;
		queue_header(8'h3C, 40, -1, 8'h00);
		queue_payload(40);
		frame_bytes = 60;
		while (frame_bytes < 200) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				queue_payload($urandom_range(1, 6));
			end else if (pick < 14) begin
				queue_tag($urandom_range(1, 5));
				pending_bytes.push_back($urandom_range(1) ? byte_t'("I") : byte_t'($urandom));
			end else if (pick < 24) begin
				n = $urandom_range(LENGTH_DIGITS_DEF - 1);
				if ($urandom_range(1))
					queue_header(byte_t'($urandom), $urandom_range(1, 20), n, non_digit());
				else
					queue_header(byte_t'($urandom), 64'd4294967296 + $urandom, -1, 8'h00);
				frame_bytes += 20;
			end else begin
				n = $urandom_range(99);
				if (n < 6)
					len = 0;
				else if (n < 20)
					len = $urandom_range(13, 40);
				else
					len = $urandom_range(1, 12);
				queue_header(byte_t'($urandom), len, -1, 8'h00);
				queue_payload(len);
				frame_bytes += 20 + len;
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("sent %0d bytes; checked %0d frames (%0d empty) and %0d payload bytes",
			in_count, frames_seen, empty_seen, payload_seen);
		$display("input stalled %0d cycles during the output hold-off", hold_stalls);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
